// ===== rtl/npsd_pkg.sv =====
// ============================================================================
// npsd_pkg: shared definitions for the nearest point search
// Field widths, stream packing sizes, opcodes and the square root interface.
// ============================================================================
package npsd_pkg;

    localparam int COORD_W     = 34;  // signed millimetre coordinate
    localparam int LABEL_W     = 32;  // four-character label
    localparam int SLOT_W      = 6;   // slot field of a load
    localparam int COUNT_W     = 7;   // point count register
    localparam int FOUND_IDX_W = 6;   // index field of a result
    localparam int DIST_W      = 35;  // saturated root
    localparam int DIFF_W      = COORD_W + 1;       // absolute coordinate difference
    localparam int HALF_W      = 18;                // multiplier narrow operand
    localparam int PROD_W      = DIFF_W + HALF_W;   // one partial product
    localparam int SQ_W        = 72;                // sum of three squares
    localparam int ROOT_W      = 38;                // full root before saturation
    localparam int REM_W       = ROOT_W + 3;        // square root remainder
    localparam int ROOT_CNT_W  = 6;                 // root iteration counter

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 176;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// ===== rtl/nearest_point_search_3d.sv =====
// ============================================================================
// nearest_point_search_3d: linear-scan nearest neighbor over a point table
// Stores reference points with labels, finds the stored point nearest to a
// client position by squared Euclidean distance and reports its root.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ---------------------------------
// cfg       in         cfg_valid/cfg_ready  cfg_data: point_count
// s         in         s_tvalid/s_tready    s_tuser: opcode; s_tdata: load/query
// m         out        m_tvalid/m_tready    m_tuser: empty_res; m_tdata: result
//
// A load is written straight into the table and leaves the sequencer idle.
// For a query, each searched point costs a table read, the three coordinate
// differences formed together, the three squares built from low and high
// halves on the shared 35x18 multiplier-accumulator and a compare, and the
// root is then found on the bit-serial square root unit. A query on an empty
// table goes from idle straight to its finish state.
// Reset (aresetn low at a clock edge) clears the sequencer, the count and the
// output valid; the point table is not cleared and is only meaningful once
// written. The input is ready only while the sequencer is idle. A finished
// result sits in the output register until its transfer, and the next input
// item is taken meanwhile; a query then waits at its end for the register.
//
module nearest_point_search_3d #(
    parameter int TABLE_DEPTH = npsd_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [npsd_pkg::COUNT_W-1:0]     cfg_data,    // point_count

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // slot[5:0], pos_x[39:6], pos_y[73:40], pos_z[107:74], label[139:108]
    input  logic [npsd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,     // opcode

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // found_index[5:0], found_label[37:6], found_x[71:38], found_y[105:72],
    // found_z[139:106], distance[174:140]
    output logic [npsd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser      // empty_res
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_DIFF  = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_START = 3'd5;
    localparam logic [2:0] ST_ROOT  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [2:0] MAC_LAST = 3'd5;

    // Control state.
    logic [2:0]                       state_reg;
    logic [npsd_pkg::COUNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic [CNT_W-1:0]                 n_reg;
    logic [2:0]                       mac_cnt_reg;
    logic                             m_valid_reg;
    logic                             empty_reg;

    // Datapath registers.
    npsd_pkg::point_t                 mem [TABLE_DEPTH];
    npsd_pkg::point_t                 rd_reg;
    npsd_pkg::point_t                 best_pt_reg;
    logic [npsd_pkg::COORD_W-1:0]     q_x_reg, q_y_reg, q_z_reg;
    logic [npsd_pkg::DIFF_W-1:0]      dx_reg, dy_reg, dz_reg;
    logic [npsd_pkg::SQ_W-1:0]        acc_reg;
    logic [npsd_pkg::SQ_W-1:0]        best_d_reg;
    logic [IDX_W-1:0]                 best_idx_reg;
    logic [npsd_pkg::DIST_W-1:0]      dist_reg;
    logic [npsd_pkg::M_TDATA_W-1:0]   m_data_reg;
    logic                             m_user_reg;

    // Input fields.
    logic [npsd_pkg::SLOT_W-1:0]      in_slot;
    logic [npsd_pkg::COORD_W-1:0]     in_x, in_y, in_z;
    logic [npsd_pkg::LABEL_W-1:0]     in_label;

    logic                             in_xfer;
    logic                             slot_ok;
    logic [CNT_W-1:0]                 n_clamp;
    logic [npsd_pkg::DIFF_W-1:0]      d_sel;
    logic [npsd_pkg::HALF_W-1:0]      h_sel;
    logic [npsd_pkg::PROD_W-1:0]      prod;
    logic [npsd_pkg::SQ_W-1:0]        term;
    logic                             better;
    logic                             last_pt;
    logic                             out_free;

    npsd_pkg::sqrt_req_t              sqrt_req;
    npsd_pkg::sqrt_rsp_t              sqrt_rsp;

    // Absolute difference of two signed coordinates; one extra bit holds it.
    function automatic logic [npsd_pkg::DIFF_W-1:0] abs_diff(
        input logic [npsd_pkg::COORD_W-1:0] a,
        input logic [npsd_pkg::COORD_W-1:0] b
    );
        logic [npsd_pkg::DIFF_W-1:0] d;
        d = {a[npsd_pkg::COORD_W-1], a} - {b[npsd_pkg::COORD_W-1], b};
        return d[npsd_pkg::DIFF_W-1] ? (~d + 1'b1) : d;
    endfunction

    assign in_slot  = s_tdata[5:0];
    assign in_x     = s_tdata[39:6];
    assign in_y     = s_tdata[73:40];
    assign in_z     = s_tdata[107:74];
    assign in_label = s_tdata[139:108];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign slot_ok   = (32'(in_slot) < TABLE_DEPTH);
    assign n_clamp   = (32'(count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(count_reg);

    // The shared multiplier works through the three axes, low half of the
    // difference first and then the high half, shifted into place.
    always_comb begin
        case (mac_cnt_reg[2:1])
            2'd0:    d_sel = dx_reg;
            2'd1:    d_sel = dy_reg;
            default: d_sel = dz_reg;
        endcase
        h_sel = mac_cnt_reg[0] ?
                npsd_pkg::HALF_W'(d_sel[npsd_pkg::DIFF_W-1:npsd_pkg::HALF_W]) :
                d_sel[npsd_pkg::HALF_W-1:0];
        prod  = npsd_pkg::PROD_W'(d_sel) * npsd_pkg::PROD_W'(h_sel);
        term  = mac_cnt_reg[0] ? (npsd_pkg::SQ_W'(prod) << npsd_pkg::HALF_W)
                               : npsd_pkg::SQ_W'(prod);
    end

    // Only a strictly smaller distance replaces the best, so ties keep
    // the lower slot.
    assign better   = (idx_reg == '0) || (acc_reg < best_d_reg);
    assign last_pt  = ((CNT_W'(idx_reg) + CNT_W'(1)) >= n_reg);
    assign out_free = !m_valid_reg || m_tready;

    assign sqrt_req.start = (state_reg == ST_START);
    assign sqrt_req.value = best_d_reg;

    npsd_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    // Point table: written by loads, read one slot per cycle with the read
    // data registered.
    always_ff @(posedge aclk) begin
        if (in_xfer && (s_tuser == npsd_pkg::OP_LOAD) && slot_ok) begin
            mem[IDX_W'(in_slot)] <= '{label: in_label, z: in_z, y: in_y, x: in_x};
        end
        rd_reg <= mem[idx_reg];
    end

    // Sequencer and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            n_reg       <= '0;
            mac_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            empty_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            // A finished query loads the output register as soon as it is
            // free; otherwise a transfer empties it.
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer && (s_tuser == npsd_pkg::OP_QUERY)) begin
                        n_reg   <= n_clamp;
                        idx_reg <= '0;
                        if (n_clamp == '0) begin
                            empty_reg <= 1'b1;
                            state_reg <= ST_DONE;
                        end else begin
                            empty_reg <= 1'b0;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    mac_cnt_reg <= '0;
                    state_reg   <= ST_MAC;
                end
                ST_MAC: begin
                    mac_cnt_reg <= mac_cnt_reg + 1'b1;
                    if (mac_cnt_reg == MAC_LAST) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (last_pt) begin
                        state_reg <= ST_START;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_START: begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (sqrt_rsp.done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            q_x_reg <= in_x;
            q_y_reg <= in_y;
            q_z_reg <= in_z;
        end
        if (state_reg == ST_DIFF) begin
            dx_reg  <= abs_diff(rd_reg.x, q_x_reg);
            dy_reg  <= abs_diff(rd_reg.y, q_y_reg);
            dz_reg  <= abs_diff(rd_reg.z, q_z_reg);
            acc_reg <= '0;
        end
        if (state_reg == ST_MAC) begin
            acc_reg <= acc_reg + term;
        end
        if ((state_reg == ST_CMP) && better) begin
            best_d_reg   <= acc_reg;
            best_idx_reg <= idx_reg;
            best_pt_reg  <= rd_reg;
        end
        if ((state_reg == ST_ROOT) && sqrt_rsp.done) begin
            dist_reg <= sqrt_rsp.root;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_user_reg <= empty_reg;
            if (empty_reg) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg <= {1'b0, dist_reg, best_pt_reg.z, best_pt_reg.y,
                               best_pt_reg.x, best_pt_reg.label,
                               npsd_pkg::FOUND_IDX_W'(best_idx_reg)};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // The root unit reports completion only while the sequencer waits on it.
    a_root_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_rsp.done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside its wait state");

    // A root is started only on an idle root unit.
    a_root_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |-> !sqrt_rsp.busy)
        else $error("square root started while busy");

    // The scan never compares a slot beyond the searched count.
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (CNT_W'(idx_reg) < n_reg))
        else $error("scan index beyond searched count");

    // A finished query holds while the output register is still occupied.
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && m_valid_reg && !m_tready)
        |=> ((state_reg == ST_DONE) && m_valid_reg))
        else $error("result overwrote a pending output");

endmodule

// ===== rtl/npsd_isqrt.sv =====
// ============================================================================
// npsd_isqrt: iterative integer square root
// Restoring digit recurrence, one root bit per cycle, saturated result.
// ============================================================================
module npsd_isqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  npsd_pkg::sqrt_req_t req,
    output npsd_pkg::sqrt_rsp_t rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [npsd_pkg::ROOT_CNT_W-1:0]     cnt_reg;
    logic [2*npsd_pkg::ROOT_W-1:0]       rad_reg;
    logic [npsd_pkg::REM_W-1:0]          rem_reg;
    logic [npsd_pkg::ROOT_W-1:0]         root_reg;

    logic [npsd_pkg::REM_W-1:0]          rem_sh;
    logic [npsd_pkg::REM_W-1:0]          trial;
    logic                                fits;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        rem_sh = {rem_reg[npsd_pkg::REM_W-3:0], rad_reg[2*npsd_pkg::ROOT_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= npsd_pkg::ROOT_CNT_W'(npsd_pkg::ROOT_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            rad_reg  <= (2*npsd_pkg::ROOT_W)'(req.value);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[npsd_pkg::ROOT_W-2:0], fits};
        end
    end

    always_comb begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        rsp.root = (root_reg > npsd_pkg::ROOT_W'(npsd_pkg::DIST_MAX)) ?
                   npsd_pkg::DIST_MAX : root_reg[npsd_pkg::DIST_W-1:0];
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for nearest_point_search_3d
// Loads reference points, sets the searched point count and sends queries.
// Every result transfer is checked field by field against a predictor that
// keeps its own copy of the point table and the count. A short table of
// directed items comes first, then a fill of every slot, then random phases under varying back-pressure.
// ============================================================================
module testbench;

    localparam int    COORD_W        = npsd_pkg::COORD_W;
    localparam int    LABEL_W        = npsd_pkg::LABEL_W;
    localparam int    SLOT_W         = npsd_pkg::SLOT_W;
    localparam int    COUNT_W        = npsd_pkg::COUNT_W;
    localparam int    FOUND_IDX_W    = npsd_pkg::FOUND_IDX_W;
    localparam int    DIST_W         = npsd_pkg::DIST_W;
    localparam int    DIFF_W         = npsd_pkg::DIFF_W;
    localparam int    ROOT_W         = npsd_pkg::ROOT_W;
    localparam int    S_TDATA_W      = npsd_pkg::S_TDATA_W;
    localparam int    M_TDATA_W      = npsd_pkg::M_TDATA_W;
    localparam logic [DIST_W-1:0] DIST_MAX = npsd_pkg::DIST_MAX;
    localparam logic  OP_LOAD        = npsd_pkg::OP_LOAD;
    localparam logic  OP_QUERY       = npsd_pkg::OP_QUERY;

    localparam int    DEPTH          = npsd_pkg::DEFAULT_TABLE_DEPTH;
    localparam int    PAD_W          = S_TDATA_W - (SLOT_W + 3 * COORD_W + LABEL_W);
    localparam int    PHASES         = 12;
    localparam int    PHASE_ITEMS    = 110;
    localparam int    HOLD_CYCLES    = 2500;  // one long receiver hold-off
    localparam int    LOAD_SETTLE    = 8;     // quiet cycles after the last load
    localparam int    QUERY_SETTLE   = 700;   // longer than a full 64-point query
    localparam int    IDLE_HEAVY_PCT = 62;
    localparam int    IDLE_LIGHT_PCT = 16;
    localparam longint RUN_LIMIT_NS  = 50_000_000;

    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
    typedef enum {ROW_ITEM, ROW_SET_COUNT} row_kind_e;

    // One result of a query, as it travels on the result stream.
    typedef struct {
        logic [FOUND_IDX_W-1:0] index;
        logic [LABEL_W-1:0]     label;
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic [COORD_W-1:0]     z;
        logic [DIST_W-1:0]      distance;
        logic                   empty;
    } nearest_hit_t;

    // One row of the directed stimulus table. A row either sends an item or
    // writes the point count; a query row may carry a hand-written result.
    typedef struct {
        row_kind_e                 kind;
        logic                      op;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [LABEL_W-1:0]        label;
        logic [COUNT_W-1:0]        count;
        bit                        typed;
        nearest_hit_t              hit;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Predictor state: the point table as the block should hold it, which
    // slots have been written, and the count that queries search.
    logic signed [COORD_W-1:0] site_x     [DEPTH];
    logic signed [COORD_W-1:0] site_y     [DEPTH];
    logic signed [COORD_W-1:0] site_z     [DEPTH];
    logic [LABEL_W-1:0]        site_label [DEPTH];
    bit                        site_written [DEPTH];
    logic [COUNT_W-1:0]        search_count = '0;

    nearest_hit_t pending_hits [$];
    plan_row_t    plan_rows [$];
    int           mismatch_count = 0;
    idle_mode_e   idle_mode      = IDLE_NONE;

    // The stimulus asks for a long hold-off by bumping hold_asked; the
    // result side owns the cycle counter.
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nearest_point_search_3d #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic nearest_hit_t empty_hit();
        nearest_hit_t h;
        h.index    = '0;
        h.label    = '0;
        h.x        = '0;
        h.y        = '0;
        h.z        = '0;
        h.distance = '0;
        h.empty    = 1'b1;
        return h;
    endfunction

    function automatic void queue_hit(input nearest_hit_t h);
        pending_hits.insert(pending_hits.size(), h);
    endfunction

    function automatic void add_row(input plan_row_t r);
        plan_rows.insert(plan_rows.size(), r);
    endfunction

    function automatic logic signed [COORD_W-1:0] mm(input int v);
        return COORD_W'(v);
    endfunction

    // Floored square root, found bit by bit from the top. The largest root of
    // three squared 35-bit differences fits well below 38 bits.
    function automatic logic [DIST_W-1:0] floor_root(input logic [73:0] v);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] c;
        logic [75:0]       cc;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            c  = r | (ROOT_W'(1) << b);
            cc = 76'(c) * 76'(c);
            if (cc <= {2'b00, v})
                r = c;
        end
        if (r > {{(ROOT_W-DIST_W){1'b0}}, DIST_MAX})
            return DIST_MAX;
        return r[DIST_W-1:0];
    endfunction

    // Linear scan over the searched slots. Only a strictly smaller squared
    // distance replaces the current best, so ties stay with the lower slot.
    function automatic nearest_hit_t find_nearest(input logic signed [COORD_W-1:0] qx,
                                                  input logic signed [COORD_W-1:0] qy,
                                                  input logic signed [COORD_W-1:0] qz);
        nearest_hit_t             hit;
        int                       n;
        int                       best;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic signed [73:0]       sq;
        logic signed [73:0]       best_sq;
        n    = (search_count > DEPTH) ? DEPTH : int'(search_count);
        hit  = empty_hit();
        best = 0;
        best_sq = '0;
        if (n == 0)
            return hit;
        for (int i = 0; i < n; i++) begin
            dx = DIFF_W'(site_x[i]) - DIFF_W'(qx);
            dy = DIFF_W'(site_y[i]) - DIFF_W'(qy);
            dz = DIFF_W'(site_z[i]) - DIFF_W'(qz);
            sq = 74'(dx) * 74'(dx) + 74'(dy) * 74'(dy) + 74'(dz) * 74'(dz);
            if (i == 0 || sq < best_sq) begin
                best    = i;
                best_sq = sq;
            end
        end
        hit.index    = best[FOUND_IDX_W-1:0];
        hit.label    = site_label[best];
        hit.x        = site_x[best];
        hit.y        = site_y[best];
        hit.z        = site_z[best];
        hit.distance = floor_root(best_sq);
        hit.empty    = 1'b0;
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check every transfer, then decide m_tready for the next
    // edge. Only one nonblocking write of m_tready happens per edge.
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic check_hit(input nearest_hit_t got);
        nearest_hit_t want;
        if (pending_hits.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, got index %0d",
                     $time, got.index);
            return;
        end
        want = pending_hits.pop_front();
        compare_field("found_index", 64'(want.index),    64'(got.index));
        compare_field("found_label", 64'(want.label),    64'(got.label));
        compare_field("found_x",     64'(want.x),        64'(got.x));
        compare_field("found_y",     64'(want.y),        64'(got.y));
        compare_field("found_z",     64'(want.z),        64'(got.z));
        compare_field("distance",    64'(want.distance), 64'(got.distance));
        compare_field("empty_res",   64'(want.empty),    64'(got.empty));
    endtask

    always @(posedge aclk) begin : result_side
        nearest_hit_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.index    = m_tdata[5:0];
            got.label    = m_tdata[37:6];
            got.x        = m_tdata[71:38];
            got.y        = m_tdata[105:72];
            got.z        = m_tdata[139:106];
            got.distance = m_tdata[174:140];
            got.empty    = m_tuser;
            check_hit(got);
        end
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECV: m_tready <= ($urandom_range(0, 99) >= IDLE_HEAVY_PCT);
                IDLE_BOTH: m_tready <= ($urandom_range(0, 99) >= IDLE_LIGHT_PCT);
                default:   m_tready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one item and returns in the time step of its transfer. The
    // predictor is updated at that point: loads go into the table, queries
    // leave one expected result behind (hand-written or predicted).
    task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                             input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic signed [COORD_W-1:0] pz,
                             input logic [LABEL_W-1:0] label,
                             input bit typed, input nearest_hit_t typed_hit);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? IDLE_HEAVY_PCT :
                  (idle_mode == IDLE_BOTH) ? IDLE_LIGHT_PCT : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, label, pz, py, px, slot};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (op == OP_LOAD) begin
            site_x[slot]       = px;
            site_y[slot]       = py;
            site_z[slot]       = pz;
            site_label[slot]   = label;
            site_written[slot] = 1'b1;
        end else if (typed) begin
            queue_hit(typed_hit);
        end else begin
            queue_hit(find_nearest(px, py, pz));
        end
    endtask

    // Stops offering items until every expected result has been taken, then
    // lets the block finish whatever load it may still be working on.
    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // The count register is only written with the block idle.
    task automatic set_count(input logic [COUNT_W-1:0] value);
        wait_idle(LOAD_SETTLE);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid    <= 1'b0;
        search_count = value;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic plan_row_t item_row(input logic op, input logic [SLOT_W-1:0] slot,
                                           input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py,
                                           input logic signed [COORD_W-1:0] pz,
                                           input logic [LABEL_W-1:0] label);
        plan_row_t r;
        r.kind  = ROW_ITEM;
        r.op    = op;
        r.slot  = slot;
        r.x     = px;
        r.y     = py;
        r.z     = pz;
        r.label = label;
        r.count = '0;
        r.typed = 1'b0;
        r.hit   = empty_hit();
        return r;
    endfunction

    function automatic plan_row_t count_row(input logic [COUNT_W-1:0] value);
        plan_row_t r;
        r       = item_row(OP_LOAD, '0, '0, '0, '0, '0);
        r.kind  = ROW_SET_COUNT;
        r.count = value;
        return r;
    endfunction

    function automatic plan_row_t typed_row(input logic signed [COORD_W-1:0] px,
                                            input logic signed [COORD_W-1:0] py,
                                            input logic signed [COORD_W-1:0] pz,
                                            input nearest_hit_t h);
        plan_row_t r;
        r       = item_row(OP_QUERY, '0, px, py, pz, '0);
        r.typed = 1'b1;
        r.hit   = h;
        return r;
    endfunction

    // A query sitting exactly on a stored point: that point, distance zero.
    function automatic nearest_hit_t exact_hit(input int idx, input logic [LABEL_W-1:0] label,
                                               input logic [COORD_W-1:0] px,
                                               input logic [COORD_W-1:0] py,
                                               input logic [COORD_W-1:0] pz);
        nearest_hit_t h;
        h.index    = idx[FOUND_IDX_W-1:0];
        h.label    = label;
        h.x        = px;
        h.y        = py;
        h.z        = pz;
        h.distance = '0;
        h.empty    = 1'b0;
        return h;
    endfunction

    function automatic logic signed [COORD_W-1:0] any_coord();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_coord();
        case ($urandom_range(0, 4))
            0:       return CMIN;
            1:       return CMAX;
            2:       return '0;
            3:       return '1;
            default: return COORD_W'(1);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] jitter(input logic signed [COORD_W-1:0] c,
                                                         input int unsigned span);
        logic signed [COORD_W-1:0] off;
        off = COORD_W'($urandom_range(0, 2 * span));
        off = off - COORD_W'(span);
        return c + off;
    endfunction

    // Points for loads and clients for queries. Up to 45 percent land on or near a
    // stored point so the scan has close competitors and exact ties; the rest are
    // spread near the origin, over the whole range or pinned to the coordinate extremes.
    task automatic pick_point(input bit for_query,
                              output logic signed [COORD_W-1:0] px,
                              output logic signed [COORD_W-1:0] py,
                              output logic signed [COORD_W-1:0] pz);
        int          pick;
        int          lim;
        int          near;
        int unsigned span;
        lim = (search_count == 0 || search_count > DEPTH) ? DEPTH : int'(search_count);
        if (!for_query)
            lim = DEPTH;
        near = $urandom_range(0, lim - 1);
        span = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 1 << 20);
        pick = $urandom_range(0, 99);
        if (pick < 45 && site_written[near]) begin
            px = jitter(site_x[near], span);
            py = jitter(site_y[near], span);
            pz = jitter(site_z[near], span);
        end else if (pick < 60) begin
            px = jitter('0, 1 << 20);
            py = jitter('0, 1 << 20);
            pz = jitter('0, 1 << 20);
        end else if (pick < 85) begin
            px = any_coord();
            py = any_coord();
            pz = any_coord();
        end else begin
            px = edge_coord();
            py = edge_coord();
            pz = edge_coord();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        logic                      op;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [COUNT_W-1:0]        count_value;
        int                        phase_counts [PHASES];

        phase_counts = '{64, 1, 127, 0, 3, 2, 64, 8, 1, 16, 5, 0};

        // Directed table. Right after reset the count is zero, so queries
        // come back empty whatever their fields hold.
        add_row(typed_row('0, '0, '0, empty_hit()));
        add_row(item_row(OP_QUERY, '1, CMAX, CMAX, CMAX, '1));
        add_row(item_row(OP_LOAD, SLOT_W'(0), CMIN, CMAX, CMIN, 32'hFFFF_FFFF));
        add_row(count_row(COUNT_W'(1)));
        // Client at the opposite corner: the largest distance there is.
        add_row(item_row(OP_QUERY, SLOT_W'(0), CMAX, CMIN, CMAX, '0));
        add_row(typed_row(CMIN, CMAX, CMIN, exact_hit(0, 32'hFFFF_FFFF, CMIN, CMAX, CMIN)));
        // Slot 1 duplicates slot 0, so the tie has to go to slot 0.
        add_row(item_row(OP_LOAD, SLOT_W'(1), CMIN, CMAX, CMIN, 32'h4142_4344));
        add_row(item_row(OP_LOAD, SLOT_W'(2), '0, '0, '0, '0));
        add_row(item_row(OP_LOAD, SLOT_W'(3), CMAX, CMAX, CMAX, 32'h5A5A_A5A5));
        add_row(count_row(COUNT_W'(4)));
        add_row(typed_row(CMIN, CMAX, CMIN, exact_hit(0, 32'hFFFF_FFFF, CMIN, CMAX, CMIN)));
        add_row(typed_row('0, '0, '0, exact_hit(2, '0, '0, '0, '0)));
        add_row(typed_row(CMAX, CMAX, CMAX, exact_hit(3, 32'h5A5A_A5A5, CMAX, CMAX, CMAX)));
        add_row(item_row(OP_QUERY, SLOT_W'(0), mm(1), mm(1), mm(1), '0));
        // The top slot is written but lies outside the searched range.
        add_row(item_row(OP_LOAD, SLOT_W'(DEPTH - 1), mm(3), mm(4), mm(-12), 32'h7E7E_7E7E));
        add_row(item_row(OP_LOAD, SLOT_W'(4), mm(-1), mm(-1), mm(-1), 32'h0000_0001));
        add_row(count_row(COUNT_W'(5)));
        add_row(item_row(OP_QUERY, SLOT_W'(0), mm(0), mm(0), mm(12), '0));
        add_row(typed_row(mm(-1), mm(-1), mm(-1), exact_hit(4, 32'h0000_0001, '1, '1, '1)));
        // A populated table with the count back at zero still answers empty.
        add_row(count_row(COUNT_W'(0)));
        add_row(typed_row(mm(5), mm(5), mm(5), empty_hit()));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan_rows[i]) begin
            if (plan_rows[i].kind == ROW_SET_COUNT)
                set_count(plan_rows[i].count);
            else
                send_item(plan_rows[i].op, plan_rows[i].slot, plan_rows[i].x,
                          plan_rows[i].y, plan_rows[i].z, plan_rows[i].label,
                          plan_rows[i].typed, plan_rows[i].hit);
        end

        // Fill every slot so that any count, up to the largest one the
        // register holds, searches written slots only.
        idle_mode = IDLE_SEND;
        for (int s = 0; s < DEPTH; s++) begin
            pick_point(1'b0, px, py, pz);
            send_item(OP_LOAD, SLOT_W'(s), px, py, pz, $urandom, 1'b0, empty_hit());
        end

        // Random phases: each one sets a count and an idling pattern, then
        // sends a mix of loads and queries.
        for (int ph = 0; ph < PHASES; ph++) begin
            count_value = COUNT_W'(phase_counts[ph]);
            if (ph % 5 == 4)
                count_value = COUNT_W'($urandom_range(1, 20));
            set_count(count_value);
            idle_mode = idle_mode_e'(ph % 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // The receiver holds off for a long stretch while items keep
                // coming, so the output register fills and the input stalls.
                if (ph == 4 && k == 30)
                    hold_asked++;
                // Here the sender goes quiet until every result is back.
                if (ph == 6 && k == 55)
                    wait_idle(LOAD_SETTLE);
                op = ($urandom_range(0, 99) < 60) ? OP_QUERY : OP_LOAD;
                pick_point(op == OP_QUERY, px, py, pz);
                send_item(op, SLOT_W'($urandom_range(0, DEPTH - 1)), px, py, pz, $urandom,
                          1'b0, empty_hit());
            end
        end

        wait_idle(QUERY_SETTLE);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
